@@ design/mtdv_pkg.sv @@
// Shared constants for the minimum total distance vertex core.
package mtdv_pkg;
  localparam int DIST_W = 27;
  localparam int WGT_W = 16;
  localparam int ADJ_W = WGT_W + 1;
  localparam logic [DIST_W-1:0] UNREACH_COST = 27'd100000000;
  localparam logic [31:0] SUM_BOUND = 32'd10000000;
endpackage

@@ design/min_total_distance_vertex_core.sv @@
// Top level: graph median search by repeated shortest-path runs from every vertex.
// Edge item: busy through the read and compare states, and the write-back state when the edge is
// stored; not busy at all when an endpoint is out of range. Solve item: per source an init pass,
// up to n scan-and-relax rounds and a summing pass, all paced by the one distance read port.
// The result strobe follows and is never stalled; a clearing pass over all ADJ_DEPTH adjacency words
// (MAX_NODES*MAX_NODES rounded up to a power of two) then wipes the graph; the same pass runs after reset.
module min_total_distance_vertex_core #(
  parameter int MAX_NODES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [5:0]  in_node_a,
  input  logic [5:0]  in_node_b,
  input  logic [15:0] in_edge_weight,
  output logic        out_valid,
  output logic [5:0]  out_best_vertex,
  output logic [31:0] out_best_total,
  output logic        out_no_result
);
  // Index width for one vertex, count width that can also hold the vertex count itself.
  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = NW + 1;
  localparam int AW = 2 * NW;
  localparam int ADJ_DEPTH = 1 << AW;
  localparam int DW = mtdv_pkg::DIST_W;
  localparam int SUMW = (DW + CW > 33) ? DW + CW : 33;
  localparam logic [8:0] MAXN9 = 9'(MAX_NODES);

  // Sequencer states.
  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_E_RD  = 4'd2;
  localparam logic [3:0] ST_E_CMP = 4'd3;
  localparam logic [3:0] ST_E_WB  = 4'd4;
  localparam logic [3:0] ST_INIT  = 4'd5;
  localparam logic [3:0] ST_SCAN  = 4'd6;
  localparam logic [3:0] ST_RELAX = 4'd7;
  localparam logic [3:0] ST_SUM   = 4'd8;
  localparam logic [3:0] ST_NEXT  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0]     state_r, state_nxt;
  logic [5:0]     node_count_r;
  logic [AW-1:0]  clr_r, clr_nxt;
  logic [AW-1:0]  ia_r, ia_nxt, ib_r, ib_nxt;
  logic [15:0]    w_r, w_nxt;
  logic [CW-1:0]  src_r, src_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic           pend_r, pend_nxt;
  logic [NW-1:0]  pidx_r, pidx_nxt;
  logic [DW-1:0]  best_d_r, best_d_nxt;
  logic [NW-1:0]  u_r, u_nxt;
  logic           found_r, found_nxt;
  logic [MAX_NODES-1:0] vis_r, vis_nxt;
  logic [SUMW-1:0] acc_r, acc_nxt;
  logic [31:0]    best_sum_r, best_sum_nxt;
  logic [CW-1:0]  best_idx_r, best_idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [5:0]     out_vert_r, out_vert_nxt;
  logic [31:0]    out_tot_r, out_tot_nxt;
  logic           out_nr_r, out_nr_nxt;

  // Memory ports.
  logic                        adj_we;
  logic [AW-1:0]               adj_wa, adj_ra;
  logic [mtdv_pkg::ADJ_W-1:0]  adj_wd, adj_rd;
  logic                        dist_we;
  logic [NW-1:0]               dist_wa, dist_ra;
  logic [DW-1:0]               dist_wd, dist_rd;

  logic [8:0]    nc9;
  logic [CW-1:0] n_act;
  logic [DW-1:0] cand;
  logic [31:0]   total;
  logic          a_ok, b_ok;

  mtdv_ram #(.WIDTH(mtdv_pkg::ADJ_W), .DEPTH(ADJ_DEPTH)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
    .raddr(adj_ra), .rdata(adj_rd)
  );

  mtdv_ram #(.WIDTH(DW), .DEPTH(1 << NW)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
    .raddr(dist_ra), .rdata(dist_rd)
  );

  // The active vertex count is the count register clamped to the number of vertices the store holds.
  assign nc9 = 9'(node_count_r);
  assign n_act = (nc9 > MAXN9) ? CW'(MAX_NODES) : CW'(node_count_r);

  assign a_ok = (in_node_a != 6'd0) && (9'(in_node_a) <= MAXN9);
  assign b_ok = (in_node_b != 6'd0) && (9'(in_node_b) <= MAXN9);

  // Relaxation candidate; the settled distance is below the unreachable cost, so it fits.
  assign cand = best_d_r + DW'(adj_rd[15:0]);
  assign total = ((acc_r >> 32) != '0) ? 32'hFFFF_FFFF : acc_r[31:0];

  assign cfg_ready = 1'b1;
  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_best_vertex = out_vert_r;
  assign out_best_total = out_tot_r;
  assign out_no_result = out_nr_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    ia_nxt = ia_r;
    ib_nxt = ib_r;
    w_nxt = w_r;
    src_nxt = src_r;
    k_nxt = k_r;
    i_nxt = i_r;
    pend_nxt = 1'b0;
    pidx_nxt = pidx_r;
    best_d_nxt = best_d_r;
    u_nxt = u_r;
    found_nxt = found_r;
    vis_nxt = vis_r;
    acc_nxt = acc_r;
    best_sum_nxt = best_sum_r;
    best_idx_nxt = best_idx_r;
    out_valid_nxt = 1'b0;
    out_vert_nxt = out_vert_r;
    out_tot_nxt = out_tot_r;
    out_nr_nxt = out_nr_r;
    adj_we = 1'b0;
    adj_wa = clr_r;
    adj_wd = '0;
    adj_ra = ia_r;
    dist_we = 1'b0;
    dist_wa = i_r[NW-1:0];
    dist_wd = mtdv_pkg::UNREACH_COST;
    dist_ra = i_r[NW-1:0];

    unique case (state_r)
      ST_CLR: begin
        adj_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(ADJ_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (!in_mode) begin
            ia_nxt = {NW'(in_node_a - 6'd1), NW'(in_node_b - 6'd1)};
            ib_nxt = {NW'(in_node_b - 6'd1), NW'(in_node_a - 6'd1)};
            w_nxt = in_edge_weight;
            if (a_ok && b_ok) begin
              state_nxt = ST_E_RD;
            end
          end else begin
            best_sum_nxt = mtdv_pkg::SUM_BOUND;
            best_idx_nxt = '0;
            src_nxt = '0;
            i_nxt = '0;
            vis_nxt = '0;
            state_nxt = (n_act == '0) ? ST_OUT : ST_INIT;
          end
        end
      end
      ST_E_RD: begin
        state_nxt = ST_E_CMP;
      end
      ST_E_CMP: begin
        // Keep only the lightest of parallel edges.
        if (!adj_rd[16] || (w_r < adj_rd[15:0])) begin
          adj_we = 1'b1;
          adj_wa = ia_r;
          adj_wd = {1'b1, w_r};
          state_nxt = ST_E_WB;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_E_WB: begin
        adj_we = 1'b1;
        adj_wa = ib_r;
        adj_wd = {1'b1, w_r};
        state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        if (i_r < n_act) begin
          dist_we = 1'b1;
          dist_wd = (i_r == src_r) ? '0 : mtdv_pkg::UNREACH_COST;
          i_nxt = i_r + 1'b1;
        end else begin
          i_nxt = '0;
          k_nxt = '0;
          best_d_nxt = mtdv_pkg::UNREACH_COST;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Reads are issued one per cycle; the data of the previous read is judged here.
        if (i_r < n_act) begin
          pend_nxt = 1'b1;
          pidx_nxt = i_r[NW-1:0];
          i_nxt = i_r + 1'b1;
        end
        if (pend_r && !vis_r[pidx_r] && (dist_rd < best_d_r)) begin
          best_d_nxt = dist_rd;
          u_nxt = pidx_r;
          found_nxt = 1'b1;
        end
        if ((i_r >= n_act) && !pend_r) begin
          i_nxt = '0;
          if (found_r) begin
            vis_nxt[u_r] = 1'b1;
            state_nxt = ST_RELAX;
          end else begin
            acc_nxt = '0;
            state_nxt = ST_SUM;
          end
        end
      end
      ST_RELAX: begin
        adj_ra = {u_r, i_r[NW-1:0]};
        if (i_r < n_act) begin
          pend_nxt = 1'b1;
          pidx_nxt = i_r[NW-1:0];
          i_nxt = i_r + 1'b1;
        end
        if (pend_r && adj_rd[16] && (cand < dist_rd)) begin
          dist_we = 1'b1;
          dist_wa = pidx_r;
          dist_wd = cand;
        end
        if ((i_r >= n_act) && !pend_r) begin
          i_nxt = '0;
          k_nxt = k_r + 1'b1;
          best_d_nxt = mtdv_pkg::UNREACH_COST;
          found_nxt = 1'b0;
          if (k_r + 1'b1 >= n_act) begin
            acc_nxt = '0;
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SUM: begin
        if (i_r < n_act) begin
          pend_nxt = 1'b1;
          i_nxt = i_r + 1'b1;
        end
        if (pend_r) begin
          acc_nxt = acc_r + SUMW'(dist_rd);
        end
        if ((i_r >= n_act) && !pend_r) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (total < best_sum_r) begin
          best_sum_nxt = total;
          best_idx_nxt = src_r + 1'b1;
        end
        src_nxt = src_r + 1'b1;
        i_nxt = '0;
        vis_nxt = '0;
        state_nxt = (src_r + 1'b1 >= n_act) ? ST_OUT : ST_INIT;
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        if (best_idx_r != '0) begin
          out_vert_nxt = 6'(best_idx_r);
          out_tot_nxt = best_sum_r;
          out_nr_nxt = 1'b0;
        end else begin
          out_vert_nxt = '0;
          out_tot_nxt = '0;
          out_nr_nxt = 1'b1;
        end
        clr_nxt = '0;
        state_nxt = ST_CLR;
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      node_count_r <= 6'd1;
      out_valid_r <= 1'b0;
      pend_r <= 1'b0;
      found_r <= 1'b0;
      vis_r <= '0;
      best_sum_r <= mtdv_pkg::SUM_BOUND;
      best_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
      pend_r <= pend_nxt;
      found_r <= found_nxt;
      vis_r <= vis_nxt;
      best_sum_r <= best_sum_nxt;
      best_idx_r <= best_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ia_r <= ia_nxt;
    ib_r <= ib_nxt;
    w_r <= w_nxt;
    src_r <= src_nxt;
    k_r <= k_nxt;
    i_r <= i_nxt;
    pidx_r <= pidx_nxt;
    best_d_r <= best_d_nxt;
    u_r <= u_nxt;
    acc_r <= acc_nxt;
    out_vert_r <= out_vert_nxt;
    out_tot_r <= out_tot_nxt;
    out_nr_r <= out_nr_nxt;
  end
endmodule

@@ design/mtdv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mtdv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ verif/tb.sv @@
// Testbench for the minimum total distance vertex core: random graphs checked against a predictor.
`timescale 1ns / 100ps

module tb;
  localparam int NMAX = 32;
  localparam int LIMIT_CYCLES = 40000000;
  localparam int MAX_PAD = 1200;

  // One item as the driver presents it: either an edge or a solve.
  typedef struct packed {
    logic        mode;
    logic [5:0]  node_a;
    logic [5:0]  node_b;
    logic [15:0] edge_weight;
  } graph_item_t;

  typedef struct packed {
    logic [5:0]  best_vertex;
    logic [31:0] best_total;
    logic        no_result;
  } median_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [5:0] cfg_data = 6'd1;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [5:0] in_node_a = 6'd0;
  logic [5:0] in_node_b = 6'd0;
  logic [15:0] in_edge_weight = 16'd0;
  logic out_valid;
  logic [5:0] out_best_vertex;
  logic [31:0] out_best_total;
  logic out_no_result;

  always #5 clk = ~clk;

  min_total_distance_vertex_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .in_mode(in_mode), .in_node_a(in_node_a), .in_node_b(in_node_b),
    .in_edge_weight(in_edge_weight),
    .out_valid(out_valid), .out_best_vertex(out_best_vertex),
    .out_best_total(out_best_total), .out_no_result(out_no_result)
  );

  // Predictor state: its own copy of the graph and of the vertex count.
  logic [16:0] graph_adj [NMAX][NMAX];
  logic [5:0]  vertex_count;

  graph_item_t pending_items[$];
  median_t     expected_medians[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  bit          hold_driver = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic queue_item(input graph_item_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic int pick_gap();
    // Mostly back to back, sometimes short, rarely long.
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sum of shortest distances from one source over the first n vertices.
  function automatic logic [31:0] distance_total(input int src, input int n);
    logic [26:0] dvec [NMAX];
    bit          done [NMAX];
    logic [63:0] acc;
    logic [26:0] best, cand;
    int u;
    for (int i = 0; i < n; i++) begin
      dvec[i] = mtdv_pkg::UNREACH_COST;
      done[i] = 1'b0;
    end
    dvec[src] = '0;
    for (int k = 0; k < n; k++) begin
      u = n;
      best = mtdv_pkg::UNREACH_COST;
      for (int i = 0; i < n; i++)
        if (!done[i] && dvec[i] < best) begin
          best = dvec[i];
          u = i;
        end
      if (u >= n) break;
      done[u] = 1'b1;
      for (int i = 0; i < n; i++)
        if (graph_adj[u][i][16]) begin
          cand = dvec[u] + 27'(graph_adj[u][i][15:0]);
          if (cand < dvec[i]) dvec[i] = cand;
        end
    end
    acc = '0;
    for (int i = 0; i < n; i++) acc += 64'(dvec[i]);
    return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
  endfunction

  // Applies one accepted item to the predictor; a solve queues its median.
  task automatic predict_item(input graph_item_t it);
    int n, bi;
    logic [31:0] bs, t;
    median_t m;
    if (!it.mode) begin
      // Out-of-range endpoints are dropped; parallel edges keep the lighter weight.
      if (it.node_a == 0 || it.node_b == 0 || it.node_a > NMAX || it.node_b > NMAX) return;
      if (!graph_adj[it.node_a-1][it.node_b-1][16] ||
          it.edge_weight < graph_adj[it.node_a-1][it.node_b-1][15:0]) begin
        graph_adj[it.node_a-1][it.node_b-1] = {1'b1, it.edge_weight};
        graph_adj[it.node_b-1][it.node_a-1] = {1'b1, it.edge_weight};
      end
    end else begin
      n = (vertex_count > NMAX) ? NMAX : vertex_count;
      bs = mtdv_pkg::SUM_BOUND;
      bi = 0;
      for (int s = 0; s < n; s++) begin
        t = distance_total(s, n);
        if (t < bs) begin
          bs = t;
          bi = s + 1;
        end
      end
      if (bi != 0) m = '{6'(bi), bs, 1'b0};
      else m = '{6'd0, 32'd0, 1'b1};
      expected_medians = {expected_medians, m};
      for (int i = 0; i < NMAX; i++)
        for (int j = 0; j < NMAX; j++) graph_adj[i][j] = '0;
    end
  endtask

  // Driver: presents queued items, with random gaps between them.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (start && !busy) begin
      predict_item({in_mode, in_node_a, in_node_b, in_edge_weight});
      void'(pending_items.pop_front());
      gap_left = pick_gap();
    end
    if (!rst_n || hold_driver || pending_items.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      {in_mode, in_node_a, in_node_b, in_edge_weight} <= pending_items[0];
    end
  end

  // Monitor: every strobed result is checked against the oldest expected median.
  always @(posedge clk) begin
    median_t want;
    if (rst_n && out_valid) begin
      if (expected_medians.size() == 0) begin
        report_mismatch("unexpected result vertex", 32'(out_best_vertex), 32'd0);
      end else begin
        want = expected_medians.pop_front();
        if (out_best_vertex !== want.best_vertex)
          report_mismatch("best_vertex", 32'(out_best_vertex), 32'(want.best_vertex));
        if (out_best_total !== want.best_total)
          report_mismatch("best_total", out_best_total, want.best_total);
        if (out_no_result !== want.no_result)
          report_mismatch("no_result", 32'(out_no_result), 32'(want.no_result));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic graph_item_t edge_item(input int a, input int b, input int w);
    return '{1'b0, 6'(a), 6'(b), 16'(w)};
  endfunction

  function automatic graph_item_t solve_item();
    // Edge fields carry junk since the block must ignore them here.
    return '{1'b1, 6'($urandom), 6'($urandom), 16'($urandom)};
  endfunction

  // Lets the driver drain the queue, then waits for the last median and the clearing pass.
  task automatic run_queue();
    hold_driver = 1'b0;
    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (MAX_PAD) @(posedge clk);
  endtask

  // Writes the vertex count while the core is idle.
  task automatic write_count(input logic [5:0] value);
    hold_driver = 1'b1;
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    vertex_count = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // A random graph: small counts most of the time, occasionally the full size.
  task automatic queue_random_graph(input int n);
    int edges, a, b, w, r;
    edges = $urandom_range(0, 3 * n);
    for (int e = 0; e < edges; e++) begin
      r = $urandom_range(0, 99);
      a = $urandom_range(1, n);
      b = $urandom_range(1, n);
      if (r < 4) a = $urandom_range(0, 63);          // noise, possibly out of range
      else if (r < 8) b = $urandom_range(n, 32);     // endpoint at or beyond the count
      case ($urandom_range(0, 3))
        0: w = $urandom_range(0, 15);
        1: w = 65535 - $urandom_range(0, 15);
        default: w = $urandom_range(0, 65535);
      endcase
      queue_item(edge_item(a, b, w));
    end
    queue_item(solve_item());
  endtask

  initial begin
    int items_sent, n;
    for (int i = 0; i < NMAX; i++)
      for (int j = 0; j < NMAX; j++) graph_adj[i][j] = '0;
    vertex_count = 6'd1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset count, empty graph and a single vertex.
    queue_item(solve_item());
    run_queue();
    write_count(6'd4);
    // Parallel edges, a self loop, out-of-range and zero endpoints, extreme weights.
    queue_item(edge_item(1, 2, 65535));
    queue_item(edge_item(2, 1, 7));
    queue_item(edge_item(1, 2, 9));
    queue_item(edge_item(3, 3, 0));
    queue_item(edge_item(0, 2, 1));
    queue_item(edge_item(33, 2, 1));
    queue_item(edge_item(63, 63, 0));
    queue_item(edge_item(2, 3, 0));
    queue_item(edge_item(3, 4, 65535));
    queue_item(edge_item(4, 20, 1));
    queue_item(solve_item());
    // Disconnected graph: nothing below the bound.
    queue_item(edge_item(1, 2, 3));
    queue_item(solve_item());
    run_queue();
    write_count(6'd0);
    queue_item(edge_item(1, 1, 5));
    queue_item(solve_item());
    run_queue();
    write_count(6'd63);
    // Full size chain with heavy weights, and count above the maximum.
    for (int i = 1; i < 32; i++) queue_item(edge_item(i, i + 1, 65535));
    queue_item(solve_item());
    run_queue();

    // Random part, sender paused until idle at every reconfiguration.
    items_sent = 0;
    while (items_sent < 1350) begin
      case ($urandom_range(0, 19))
        0: n = 32;
        1: n = $urandom_range(33, 63);
        2: n = 0;
        default: n = $urandom_range(1, 8);
      endcase
      write_count(6'(n));
      for (int g = 0; g < 3; g++)
        queue_random_graph((n == 0) ? 1 : ((n > 32) ? 32 : n));
      items_sent += pending_items.size();
      run_queue();
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
